>>> rtl/core/checked_integer_alu_assert.svh
// assertion macros for the checked integer alu
`ifndef CHECKED_INTEGER_ALU_ASSERT_SVH
`define CHECKED_INTEGER_ALU_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CIA_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CIA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/cia_pkg.sv
package cia_pkg;

  localparam int MAX_WIDTH_DEF = 64;

  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_MOD = 3'd4;
  localparam logic [2:0] FUNC_CVT = 3'd5;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_OVF  = 3'd1;
  localparam logic [2:0] ST_UNF  = 3'd2;
  localparam logic [2:0] ST_DIVZ = 3'd3;
  localparam logic [2:0] ST_MODZ = 3'd4;

  // front stages: decode, multiply partial products, product combine
  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  w;
    logic        sg;
    logic [63:0] val;
    logic [2:0]  st;
    logic [63:0] dq;
    logic [63:0] mb;
    logic        na;
    logic        nb;
    logic        dsp;
    logic        mneg;
    logic [63:0] xa;
    logic [63:0] xb;
    logic [63:0] lim;
    logic [63:0] pll;
    logic [63:0] plh;
    logic [63:0] phl;
    logic [63:0] phh;
    logic [63:0] hi;
    logic [63:0] lo;
  } front_t;

  // divider chain record
  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  w;
    logic [63:0] val;
    logic [2:0]  st;
    logic [63:0] dq;
    logic [63:0] rm;
    logic [63:0] mb;
    logic        na;
    logic        nb;
    logic        dsp;
  } div_t;

  function automatic logic [6:0] width_of(input logic [1:0] code, input int maxw);
    logic [6:0] w;
    w = 7'd8 << code;
    return (w > 7'(maxw)) ? 7'(maxw) : w;
  endfunction

  function automatic logic [63:0] mask_of(input logic [6:0] w);
    return (w >= 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] sign_bit(input logic [6:0] w);
    return 64'd1 << (w - 7'd1);
  endfunction

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [6:0] w);
    return ((v & sign_bit(w)) != 64'd0) ? (v | ~mask_of(w)) : v;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

>>> rtl/core/checked_integer_alu.sv
// checked integer alu: add, subtract, multiply, divide, modulo and range-checked
// conversion at 8/16/32/64 bits, signed or unsigned, with a status code per item.
// fully pipelined: one item can be transferred in every cycle while no result is held,
// and every item passes through all stages, whatever its operation. the depth
// is set by the divider, one quotient bit per stage over MAX_WIDTH stages; the
// multiplier takes three stages (partial products, combine, flags) ahead of the divider
// chain. a stalled result freezes the whole pipeline, so nothing is lost
// or repeated; while the output register is free, stall stays low.
module checked_integer_alu #(
  parameter int MAX_WIDTH = cia_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        valid,
  output logic        stall,
  input  logic [2:0]  func,
  input  logic [1:0]  width_code,
  input  logic        is_signed,
  input  logic [1:0]  dest_width_code,
  input  logic        dest_signed,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [63:0] result_value,
  output logic [2:0]  status
);

  localparam int DSTG = MAX_WIDTH;

  // whole pipeline advances together unless a result is held
  logic adv;
  assign adv   = !res_valid || !res_stall;
  assign stall = !adv;

  // stage 1: input register
  logic        v1;
  logic [2:0]  f1;
  logic [1:0]  wc1;
  logic        sg1;
  logic [1:0]  dwc1;
  logic        dsg1;
  logic [63:0] a1;
  logic [63:0] b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1   <= func;
      wc1  <= width_code;
      sg1  <= is_signed;
      dwc1 <= dest_width_code;
      dsg1 <= dest_signed;
      a1   <= operand_a;
      b1   <= operand_b;
    end
  end

  // stage 2: decode, add/sub/convert results, multiply and divide operands
  cia_pkg::front_t s2_next;
  cia_pkg::front_t s2;
  logic            v2;

  always_comb begin
    logic [6:0]  w;
    logic [6:0]  dw;
    logic [63:0] m;
    logic [63:0] dm;
    logic [63:0] sb;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] ea;
    logic [63:0] eb;
    logic [63:0] sum;
    logic [63:0] dif;
    logic [63:0] src;
    logic        cneg;
    logic [63:0] mg;
    logic [63:0] dmax;
    logic [2:0]  cst;
    w    = cia_pkg::width_of(wc1, MAX_WIDTH);
    dw   = cia_pkg::width_of(dwc1, MAX_WIDTH);
    m    = cia_pkg::mask_of(w);
    dm   = cia_pkg::mask_of(dw);
    sb   = cia_pkg::sign_bit(w);
    a    = a1 & m;
    b    = b1 & m;
    ea   = cia_pkg::sext(a, w);
    eb   = cia_pkg::sext(b, w);
    sum  = (a + b) & m;
    dif  = (a - b) & m;
    src  = sg1 ? ea : a;
    cneg = sg1 && src[63];
    mg   = cneg ? cia_pkg::mag64(src) : src;
    dmax = dsg1 ? (cia_pkg::sign_bit(dw) - 64'd1) : dm;
    cst  = cia_pkg::ST_OK;
    if (cneg) begin
      if (!dsg1 || (mg > cia_pkg::sign_bit(dw))) cst = cia_pkg::ST_UNF;
    end else if (mg > dmax) begin
      cst = cia_pkg::ST_OVF;
    end

    s2_next      = '0;
    s2_next.func = f1;
    s2_next.w    = w;
    s2_next.sg   = sg1;
    // multiply operands: magnitudes when signed
    s2_next.mneg = sg1 && (ea[63] ^ eb[63]);
    s2_next.xa   = sg1 ? cia_pkg::mag64(ea) : a;
    s2_next.xb   = sg1 ? cia_pkg::mag64(eb) : b;
    s2_next.lim  = (ea[63] ^ eb[63]) ? sb : (sb - 64'd1);
    // divide operands
    s2_next.na   = sg1 && ea[63];
    s2_next.nb   = sg1 && eb[63];
    s2_next.mb   = sg1 ? cia_pkg::mag64(eb) : b;
    s2_next.dq   = (sg1 ? cia_pkg::mag64(ea) : a) << (7'(64 - DSTG));

    case (f1)
      cia_pkg::FUNC_ADD: begin
        s2_next.val = sum;
        if (sg1) begin
          s2_next.st = ((((a ^ b) & sb) == 64'd0) && (((sum ^ a) & sb) != 64'd0)) ?
                       cia_pkg::ST_OVF : cia_pkg::ST_OK;
        end else begin
          s2_next.st = (sum < a) ? cia_pkg::ST_OVF : cia_pkg::ST_OK;
        end
      end
      cia_pkg::FUNC_SUB: begin
        s2_next.val = dif;
        if (sg1) begin
          s2_next.st = ((((a ^ b) & sb) != 64'd0) && (((dif ^ a) & sb) != 64'd0)) ?
                       cia_pkg::ST_UNF : cia_pkg::ST_OK;
        end else begin
          s2_next.st = (a < b) ? cia_pkg::ST_UNF : cia_pkg::ST_OK;
        end
      end
      cia_pkg::FUNC_DIV, cia_pkg::FUNC_MOD: begin
        if (b == 64'd0) begin
          s2_next.dsp = 1'b1;
          s2_next.st  = (f1 == cia_pkg::FUNC_DIV) ? cia_pkg::ST_DIVZ : cia_pkg::ST_MODZ;
        end else if (sg1 && (a == sb) && (b == m)) begin
          // signed minimum by minus one: wrapped quotient, zero remainder
          s2_next.dsp = 1'b1;
          s2_next.st  = cia_pkg::ST_OVF;
          s2_next.val = (f1 == cia_pkg::FUNC_DIV) ? sb : 64'd0;
        end
      end
      cia_pkg::FUNC_CVT: begin
        s2_next.st  = cst;
        s2_next.val = (cst == cia_pkg::ST_OK) ? (src & dm) : 64'd0;
      end
      default: begin
        s2_next.val = 64'd0;
        s2_next.st  = cia_pkg::ST_OK;
      end
    endcase
  end

  // stage 3: four 32x32 partial products
  cia_pkg::front_t s3_next;
  cia_pkg::front_t s3;
  logic            v3;

  always_comb begin
    s3_next     = s2;
    s3_next.pll = {32'd0, s2.xa[31:0]}  * {32'd0, s2.xb[31:0]};
    s3_next.plh = {32'd0, s2.xa[31:0]}  * {32'd0, s2.xb[63:32]};
    s3_next.phl = {32'd0, s2.xa[63:32]} * {32'd0, s2.xb[31:0]};
    s3_next.phh = {32'd0, s2.xa[63:32]} * {32'd0, s2.xb[63:32]};
  end

  // stage 4: combine into the 128-bit product
  cia_pkg::front_t s4_next;
  cia_pkg::front_t s4;
  logic            v4;

  always_comb begin
    logic [63:0] mid;
    mid = {32'd0, s3.pll[63:32]} + {32'd0, s3.plh[31:0]} + {32'd0, s3.phl[31:0]};
    s4_next    = s3;
    s4_next.lo = {mid[31:0], s3.pll[31:0]};
    s4_next.hi = s3.phh + {32'd0, s3.plh[63:32]} + {32'd0, s3.phl[63:32]} +
                 {32'd0, mid[63:32]};
  end

  // stage 5: multiply flags, entry to the divider chain
  cia_pkg::div_t d0_next;

  always_comb begin
    logic [63:0] m;
    logic [63:0] plo;
    logic        mst;
    m   = cia_pkg::mask_of(s4.w);
    plo = s4.mneg ? (64'd0 - s4.lo) : s4.lo;
    if (s4.sg) begin
      mst = ((s4.lo != 64'd0) || (s4.hi != 64'd0)) &&
            ((s4.hi != 64'd0) || (s4.lo > s4.lim));
    end else begin
      mst = (s4.hi != 64'd0) || ((s4.lo & ~m) != 64'd0);
    end
    d0_next      = '0;
    d0_next.func = s4.func;
    d0_next.w    = s4.w;
    d0_next.val  = s4.val;
    d0_next.st   = s4.st;
    d0_next.dq   = s4.dq;
    d0_next.rm   = 64'd0;
    d0_next.mb   = s4.mb;
    d0_next.na   = s4.na;
    d0_next.nb   = s4.nb;
    d0_next.dsp  = s4.dsp;
    if (s4.func == cia_pkg::FUNC_MUL) begin
      d0_next.val = plo & m;
      d0_next.st  = mst ? cia_pkg::ST_OVF : cia_pkg::ST_OK;
    end
  end

  cia_pkg::div_t dq_rec [DSTG+1];
  logic          dq_vld [DSTG+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      dq_vld[0] <= 1'b0;
    end else if (adv) begin
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      dq_vld[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2        <= s2_next;
      s3        <= s3_next;
      s4        <= s4_next;
      dq_rec[0] <= d0_next;
    end
  end

  // divider chain: one quotient bit per stage
  for (genvar i = 0; i < DSTG; i++) begin : g_div
    cia_div_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .in_vld  (dq_vld[i]),
      .in_rec  (dq_rec[i]),
      .out_vld (dq_vld[i+1]),
      .out_rec (dq_rec[i+1])
    );
  end

  // final stage: sign fix of quotient or remainder, output register
  logic [63:0] fin_val;

  always_comb begin
    cia_pkg::div_t r;
    logic [63:0]   q;
    logic [63:0]   rem;
    r   = dq_rec[DSTG];
    q   = (r.na != r.nb) ? (64'd0 - r.dq) : r.dq;
    rem = r.na ? (64'd0 - r.rm) : r.rm;
    fin_val = r.val;
    if (!r.dsp && (r.func == cia_pkg::FUNC_DIV)) begin
      fin_val = q & cia_pkg::mask_of(r.w);
    end else if (!r.dsp && (r.func == cia_pkg::FUNC_MOD)) begin
      fin_val = rem & cia_pkg::mask_of(r.w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= dq_vld[DSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_value <= fin_val;
      status       <= dq_rec[DSTG].st;
    end
  end

endmodule

>>> rtl/core/cia_div_stage.sv
module cia_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  cia_pkg::div_t in_rec,
  output logic          out_vld,
  output cia_pkg::div_t out_rec
);

  logic [64:0]   t;
  logic          ge;
  logic [64:0]   diff;
  cia_pkg::div_t rec_next;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    t        = {in_rec.rm, in_rec.dq[63]};
    diff     = t - {1'b0, in_rec.mb};
    ge       = (t >= {1'b0, in_rec.mb});
    rec_next = in_rec;
    rec_next.dq = {in_rec.dq[62:0], ge};
    rec_next.rm = ge ? diff[63:0] : t[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rec <= rec_next;
    end
  end

endmodule

>>> rtl/core/cia_checker.sv
`include "checked_integer_alu_assert.svh"

module cia_checker (
  input logic        clk,
  input logic        rst,
  input logic        stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic [63:0] result_value,
  input logic [2:0]  status
);

  logic held;
  logic zero_code;

  assign held      = res_valid && res_stall;
  assign zero_code = (status == cia_pkg::ST_DIVZ) || (status == cia_pkg::ST_MODZ);

  // a held result stays put
  `CIA_ASSERT_NEXT(a_res_hold, held, res_valid && $stable({result_value, status}), "held result changed")

  // no status code beyond modulo by zero
  `CIA_ASSERT(a_status_range, res_valid, status <= cia_pkg::ST_MODZ, "status out of range")

  // divide or modulo by zero returns zero
  `CIA_ASSERT(a_zero_div_val, res_valid && zero_code, result_value == 64'd0, "nonzero on zero divisor")

  // input only blocked by a held result
  `CIA_ASSERT(a_stall_cause, stall, held, "input stalled without a held result")

endmodule

bind checked_integer_alu cia_checker u_cia_checker (.*);

>>> tb/sv/checked_integer_alu_checker.sv
`timescale 1ns / 100ps

module checked_integer_alu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic        stall,
  input  logic [2:0]  func,
  input  logic [1:0]  width_code,
  input  logic        is_signed,
  input  logic [1:0]  dest_width_code,
  input  logic        dest_signed,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [63:0] result_value,
  input  logic [2:0]  status,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  code;
  } alu_result_t;

  alu_result_t awaited_results[$];

  function automatic logic [63:0] lane_mask(input int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] top_bit(input int w);
    return 64'd1 << (w - 1);
  endfunction

  function automatic logic [63:0] widen_signed(input logic [63:0] v, input int w);
    return ((v & top_bit(w)) != 0) ? (v | ~lane_mask(w)) : v;
  endfunction

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic alu_result_t compute_alu(
    input logic [2:0] f, input logic [1:0] wc, input logic sg,
    input logic [1:0] dwc, input logic dsg, input logic [63:0] ra, input logic [63:0] rb);
    int w, dw;
    logic [63:0] m, a, b, sb, val, ea, eb, lim, q, r, src, mg, dm, dmax;
    logic [127:0] prod;
    logic [2:0] st;
    logic neg, na, nb;
    alu_result_t res;
    w = 8 << wc;
    dw = 8 << dwc;
    m = lane_mask(w);
    a = ra & m;
    b = rb & m;
    sb = top_bit(w);
    val = 64'd0;
    st = cia_pkg::ST_OK;
    case (f)
      cia_pkg::FUNC_ADD: begin
        val = (a + b) & m;
        if (sg) st = (((a ^ b) & sb) == 0 && ((val ^ a) & sb) != 0) ?
                     cia_pkg::ST_OVF : cia_pkg::ST_OK;
        else st = (val < a) ? cia_pkg::ST_OVF : cia_pkg::ST_OK;
      end
      cia_pkg::FUNC_SUB: begin
        val = (a - b) & m;
        if (sg) st = (((a ^ b) & sb) != 0 && ((val ^ a) & sb) != 0) ?
                     cia_pkg::ST_UNF : cia_pkg::ST_OK;
        else st = (a < b) ? cia_pkg::ST_UNF : cia_pkg::ST_OK;
      end
      cia_pkg::FUNC_MUL: begin
        val = (a * b) & m;
        if (sg) begin
          ea = widen_signed(a, w);
          eb = widen_signed(b, w);
          neg = ea[63] ^ eb[63];
          lim = neg ? sb : sb - 64'd1;
          prod = {64'd0, magnitude(ea)} * {64'd0, magnitude(eb)};
          if (prod != 0 && (prod[127:64] != 0 || prod[63:0] > lim)) st = cia_pkg::ST_OVF;
        end else begin
          prod = {64'd0, a} * {64'd0, b};
          if (prod[127:64] != 0 || (prod[63:0] & ~m) != 0) st = cia_pkg::ST_OVF;
        end
      end
      cia_pkg::FUNC_DIV, cia_pkg::FUNC_MOD: begin
        if (b == 0) begin
          st = (f == cia_pkg::FUNC_DIV) ? cia_pkg::ST_DIVZ : cia_pkg::ST_MODZ;
        end else if (!sg) begin
          val = (f == cia_pkg::FUNC_DIV) ? a / b : a % b;
        end else if (a == sb && b == m) begin
          val = (f == cia_pkg::FUNC_DIV) ? sb : 64'd0;
          st = cia_pkg::ST_OVF;
        end else begin
          ea = widen_signed(a, w);
          eb = widen_signed(b, w);
          q = magnitude(ea) / magnitude(eb);
          r = magnitude(ea) % magnitude(eb);
          na = ea[63];
          nb = eb[63];
          if (f == cia_pkg::FUNC_DIV) val = (na != nb) ? 64'd0 - q : q;
          else val = na ? 64'd0 - r : r;
          val &= m;
        end
      end
      cia_pkg::FUNC_CVT: begin
        dm = lane_mask(dw);
        src = sg ? widen_signed(a, w) : a;
        neg = sg && src[63];
        mg = neg ? magnitude(src) : src;
        if (neg) begin
          if (!dsg || mg > top_bit(dw)) st = cia_pkg::ST_UNF;
        end else begin
          dmax = dsg ? top_bit(dw) - 64'd1 : dm;
          if (mg > dmax) st = cia_pkg::ST_OVF;
        end
        val = (st == cia_pkg::ST_OK) ? (src & dm) : 64'd0;
      end
      default: ;
    endcase
    res.value = val;
    res.code = st;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = awaited_results.size();

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst) begin
      if (valid && !stall)
        awaited_results.push_back(compute_alu(func, width_code, is_signed,
                                              dest_width_code, dest_signed,
                                              operand_a, operand_b));
      if (res_valid && !res_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result transfer with nothing awaited");
        end else begin
          exp_r = awaited_results.pop_front();
          if (result_value !== exp_r.value)
            report_mismatch($sformatf("result_value %h, want %h", result_value, exp_r.value));
          if (status !== exp_r.code)
            report_mismatch($sformatf("status %0d, want %0d", status, exp_r.code));
        end
      end
    end
  end
endmodule

>>> tb/sv/tb_checked_integer_alu.sv
`timescale 1ns / 100ps

module tb_checked_integer_alu;

  localparam int NUM_RANDOM = 1650;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        stall;
  logic [2:0]  func = '0;
  logic [1:0]  width_code = '0;
  logic        is_signed = 1'b0;
  logic [1:0]  dest_width_code = '0;
  logic        dest_signed = 1'b0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [63:0] result_value;
  logic [2:0]  status;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  // quiet window: neither side idles while set
  logic        no_idle = 1'b0;

  always #4 clk = ~clk;

  checked_integer_alu i_dut (
    .clk, .rst, .valid, .stall, .func, .width_code, .is_signed,
    .dest_width_code, .dest_signed, .operand_a, .operand_b,
    .res_valid, .res_stall, .result_value, .status
  );

  checked_integer_alu_checker i_checker (
    .clk, .rst, .valid, .stall, .func, .width_code, .is_signed,
    .dest_width_code, .dest_signed, .operand_a, .operand_b,
    .res_valid, .res_stall, .result_value, .status,
    .fail_count, .pending
  );

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_checked_integer_alu failed");
      $finish;
    end
  end

  // result side stalls about 35 percent of cycles, except in the quiet window
  always @(posedge clk)
    res_stall <= !no_idle && ($urandom_range(99) < 35);

  // operand value biased toward edges of the lane
  function automatic logic [63:0] pick_operand(input logic [1:0] wc);
    logic [63:0] m, sb;
    m = (wc == 2'd3) ? '1 : ((64'd1 << (8 << wc)) - 64'd1);
    sb = 64'd1 << ((8 << wc) - 1);
    case ($urandom_range(9))
      0: return 64'd0;
      1: return m;
      2: return sb;
      3: return sb - 64'd1;
      4: return 64'd1;
      5: return 64'($urandom_range(3));
      6: return {$urandom, $urandom} | ~m;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // present one item and hold it until the transfer
  task automatic send_item(input logic [2:0] f, input logic [1:0] wc, input logic sg,
                           input logic [1:0] dwc, input logic dsg,
                           input logic [63:0] a, input logic [63:0] b);
    while (!no_idle && $urandom_range(99) < 35) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    func <= f;
    width_code <= wc;
    is_signed <= sg;
    dest_width_code <= dwc;
    dest_signed <= dsg;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (stall) @(posedge clk);
  endtask

  initial begin
    logic [1:0] wc;
    logic [63:0] sb, m;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every operation and the named corner cases
    send_item(cia_pkg::FUNC_ADD, 2'd0, 1'b0, 2'd0, 1'b0, 64'hff, 64'h01);
    send_item(cia_pkg::FUNC_ADD, 2'd0, 1'b1, 2'd0, 1'b0, 64'h7f, 64'h01);
    send_item(cia_pkg::FUNC_ADD, 2'd3, 1'b1, 2'd0, 1'b0, '1, 64'h8000_0000_0000_0000);
    send_item(cia_pkg::FUNC_SUB, 2'd1, 1'b0, 2'd0, 1'b0, 64'h0, 64'h1);
    send_item(cia_pkg::FUNC_SUB, 2'd2, 1'b1, 2'd0, 1'b0, 64'h7fff_ffff, 64'hffff_ffff);
    send_item(cia_pkg::FUNC_MUL, 2'd3, 1'b0, 2'd0, 1'b0, '1, '1);
    send_item(cia_pkg::FUNC_MUL, 2'd0, 1'b1, 2'd0, 1'b0, 64'h80, 64'hff);
    send_item(cia_pkg::FUNC_MUL, 2'd3, 1'b1, 2'd0, 1'b0, 64'h8000_0000_0000_0000, 64'h1);
    send_item(cia_pkg::FUNC_DIV, 2'd2, 1'b0, 2'd0, 1'b0, 64'h1234, 64'h0);
    send_item(cia_pkg::FUNC_MOD, 2'd2, 1'b1, 2'd0, 1'b0, 64'h1234, 64'h0);
    send_item(cia_pkg::FUNC_DIV, 2'd3, 1'b1, 2'd0, 1'b0, 64'h8000_0000_0000_0000, '1);
    send_item(cia_pkg::FUNC_MOD, 2'd0, 1'b1, 2'd0, 1'b0, 64'h80, 64'hff);
    send_item(cia_pkg::FUNC_DIV, 2'd0, 1'b1, 2'd0, 1'b0, 64'hf9, 64'h02);
    send_item(cia_pkg::FUNC_MOD, 2'd0, 1'b1, 2'd0, 1'b0, 64'hf9, 64'h02);
    send_item(cia_pkg::FUNC_DIV, 2'd3, 1'b0, 2'd0, 1'b0, '1, 64'h3);
    send_item(cia_pkg::FUNC_CVT, 2'd3, 1'b1, 2'd0, 1'b0, '1, '1);
    send_item(cia_pkg::FUNC_CVT, 2'd3, 1'b1, 2'd0, 1'b1, 64'hffff_ffff_ffff_ff80, 64'h0);
    send_item(cia_pkg::FUNC_CVT, 2'd3, 1'b1, 2'd0, 1'b1, 64'hffff_ffff_ffff_ff7f, 64'h0);
    send_item(cia_pkg::FUNC_CVT, 2'd1, 1'b0, 2'd0, 1'b1, 64'h80, 64'h0);
    send_item(cia_pkg::FUNC_CVT, 2'd3, 1'b0, 2'd3, 1'b1, '1, 64'h0);
    send_item(cia_pkg::FUNC_CVT, 2'd0, 1'b0, 2'd3, 1'b0, 64'hff, '1);
    send_item(3'd6, 2'd1, 1'b1, 2'd1, 1'b1, '1, '1);
    send_item(3'd7, 2'd3, 1'b0, 2'd2, 1'b0, '1, '1);

    // random part; a stretch in the middle runs with no idling
    for (int n = 0; n < NUM_RANDOM; n++) begin
      no_idle <= (n >= 600 && n < 800);
      wc = 2'($urandom_range(3));
      sb = 64'd1 << ((8 << wc) - 1);
      m = (wc == 2'd3) ? '1 : ((64'd1 << (8 << wc)) - 64'd1);
      if ($urandom_range(19) == 0)
        send_item(3'(cia_pkg::FUNC_DIV + $urandom_range(1)), wc, 1'b1,
                  2'($urandom_range(3)), 1'($urandom_range(1)), sb, m);
      else
        send_item(3'($urandom_range(7)), wc, 1'($urandom_range(1)),
                  2'($urandom_range(3)), 1'($urandom_range(1)),
                  pick_operand(wc), pick_operand(wc));
    end
    valid <= 1'b0;
    no_idle <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_checked_integer_alu passed");
    else
      $display("tb_checked_integer_alu failed");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/cia_pkg.sv
rtl/core/cia_div_stage.sv
rtl/core/checked_integer_alu.sv
rtl/core/cia_checker.sv
tb/sv/checked_integer_alu_checker.sv
tb/sv/tb_checked_integer_alu.sv
